// ----- src/lgre_pkg.sv -----
package lgre_pkg;

  // Field and register widths
  localparam int DATA_W  = 64;
  localparam int IDX_W   = 12;
  localparam int CC_W    = 7;
  localparam int RC_W    = 13;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Register select, taken from paddr[2]
  localparam logic REG_COLUMN_COUNT = 1'b0;
  localparam logic REG_ROW_COUNT    = 1'b1;

  localparam logic [CC_W-1:0] COLUMN_COUNT_RST = 7'd64;
  localparam logic [RC_W-1:0] ROW_COUNT_RST    = 13'd64;

  // B3/S23 rule
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef struct packed {
    logic [DATA_W-1:0] bits;
    logic [IDX_W-1:0]  idx;
    logic              done;
  } result_t;

  // Queue write strobes; second only comes with first
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

// ----- src/lgre_cell.sv -----
module lgre_cell import lgre_pkg::*; (
  input  logic [2:0] above,
  input  logic [2:0] here,
  input  logic [2:0] below,
  output logic       alive_next
);

  // Bit 1 of each window is this column, bits 0 and 2 its neighbors
  logic [3:0] neighbors;

  assign neighbors = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
                   + 4'(here[0])  + 4'(here[2])
                   + 4'(below[0]) + 4'(below[1]) + 4'(below[2]);

  assign alive_next = (neighbors == BIRTH_COUNT)
                    | (here[1] & (neighbors == SURVIVE_COUNT));

endmodule

// ----- src/lgre_row.sv -----
module lgre_row #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0] above,
  input  logic [WIDTH-1:0] here,
  input  logic [WIDTH-1:0] below,
  input  logic [WIDTH-1:0] mask,
  output logic [WIDTH-1:0] next_row
);

  // Cells outside the column mask and beyond both edges are dead
  logic [WIDTH+1:0] above_pad;
  logic [WIDTH+1:0] here_pad;
  logic [WIDTH+1:0] below_pad;
  logic [WIDTH-1:0] lane_out;

  assign above_pad = {1'b0, above & mask, 1'b0};
  assign here_pad  = {1'b0, here & mask, 1'b0};
  assign below_pad = {1'b0, below & mask, 1'b0};

  // One lane per column
  for (genvar c = 0; c < WIDTH; c++) begin : g_lane
    lgre_cell u_cell (
      .above      (above_pad[c+2:c]),
      .here       (here_pad[c+2:c]),
      .below      (below_pad[c+2:c]),
      .alive_next (lane_out[c])
    );
  end

  // Merge lanes, clearing unused columns
  assign next_row = lane_out & mask;

endmodule

// ----- src/lgre_outq.sv -----
module lgre_outq import lgre_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  result_t entry0,
  input  result_t entry1,
  input  logic    pop,
  output logic    valid,
  output logic    low_space,
  output result_t head_entry
);

  result_t              q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   head;
  logic [Q_PTR_W-1:0]   tail;
  logic [Q_CNT_W-1:0]   count;
  logic [Q_CNT_W-1:0]   count_next;
  logic [Q_PTR_W-1:0]   tail_plus1;

  assign tail_plus1 = tail + 1'b1;
  assign valid      = (count != '0);
  // Room for two results is needed before a row transfer
  assign low_space  = (count > Q_CNT_W'(Q_DEPTH - 2));
  assign head_entry = q[head];

  always_comb begin
    count_next = count + Q_CNT_W'(push.first) + Q_CNT_W'(push.second)
               - Q_CNT_W'(pop);
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        head <= head + 1'b1;
      end
      if (push.second) begin
        tail <= tail + 2'd2;
      end else if (push.first) begin
        tail <= tail_plus1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.first) begin
      q[tail] <= entry0;
    end
    if (push.second) begin
      q[tail_plus1] <= entry1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue overfilled");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (push.second && !pop) |-> (count <= Q_CNT_W'(Q_DEPTH - 2)))
    else $error("two results pushed without room");

endmodule

// ----- src/life_generation_row_engine.sv -----
// Life generation row engine: one B3/S23 generation over a bounded grid.
// Rows stream in on the row channel (row_valid/row_stall/row_bits), one row
// per transfer, top row first; bit c is column c. Results leave on the
// result channel (result_valid/result_stall) with next_row_bits, row_index
// and frame_done, which marks the frame's last row.
// column_count and row_count sit on the APB port at 0x0 and 0x4.
// A row's result enters the result queue when the row below it is
// transferred. The last row of a frame yields two results in that transfer,
// the row before it and itself; a one-row frame yields one.
// Throughput: one row per cycle while row_stall is low, set by the two 64-lane
// row evaluators and a four-entry result queue; a frame of N rows yields N
// results, none for its first row and two for its last, so without result
// stalls the queue never holds more than two entries and row_stall stays low.
// Stall: results wait in the queue; row_stall rises when the queue has
// fewer than two free entries, so nothing is dropped under any stall pattern.
// Reset: rows seen and stored rows clear, column_count and row_count return
// to 64, the queue empties. A frame ends after row_count rows (0 acts as 1,
// at most MAX_ROWS) and the next transfer starts a new frame.
module life_generation_row_engine import lgre_pkg::*; #(
  parameter int ROW_WIDTH = 64,
  parameter int MAX_ROWS  = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  input  logic                row_valid,
  output logic                row_stall,
  input  logic [DATA_W-1:0]   row_bits,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [DATA_W-1:0]   next_row_bits,
  output logic [IDX_W-1:0]    row_index,
  output logic                frame_done
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W = ($clog2(MAX_ROWS + 1) > RC_W) ? $clog2(MAX_ROWS + 1) : RC_W;

  logic [CC_W-1:0]      column_count;
  logic [RC_W-1:0]      row_count;
  logic [ROW_WIDTH-1:0] upper_row;
  logic [ROW_WIDTH-1:0] middle_row;
  logic [RW-1:0]        rows_seen;

  logic [CC_W-1:0]      cols_eff;
  logic [ROW_WIDTH-1:0] mask;
  logic [ROW_WIDTH-1:0] cur;
  logic [CNT_W-1:0]     rows_ext;
  logic [CNT_W-1:0]     rows_eff;
  logic [CNT_W-1:0]     seen_plus1;
  logic [CNT_W-1:0]     idx_prev_ext;
  logic [CNT_W-1:0]     idx_cur_ext;
  logic                 first_row;
  logic                 last_row;
  logic                 row_accept;
  logic [ROW_WIDTH-1:0] x_above;
  logic [ROW_WIDTH-1:0] x_here;
  logic [ROW_WIDTH-1:0] x_below;
  logic [ROW_WIDTH-1:0] x_next;
  logic [ROW_WIDTH-1:0] y_next;
  push_t                push;
  result_t              entry0;
  result_t              entry1;
  result_t              head_entry;
  logic                 q_low_space;
  logic                 pop;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= COLUMN_COUNT_RST;
      row_count    <= ROW_COUNT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_COLUMN_COUNT: column_count <= pwdata[CC_W-1:0];
        REG_ROW_COUNT:    row_count    <= pwdata[RC_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COLUMN_COUNT: prdata = APB_DW'(column_count);
      REG_ROW_COUNT:    prdata = APB_DW'(row_count);
      default:          prdata = '0;
    endcase
  end

  // Effective column count and column mask
  assign cols_eff = (column_count > CC_W'(ROW_WIDTH)) ? CC_W'(ROW_WIDTH) : column_count;

  always_comb begin
    for (int c = 0; c < ROW_WIDTH; c++) begin
      mask[c] = (CC_W'(c) < cols_eff);
    end
  end

  assign cur = row_bits[ROW_WIDTH-1:0] & mask;

  // Effective row count and frame position
  assign rows_ext = CNT_W'(row_count);

  always_comb begin
    rows_eff = rows_ext;
    if (rows_ext == '0) begin
      rows_eff = CNT_W'(1);
    end else if (rows_ext > CNT_W'(MAX_ROWS)) begin
      rows_eff = CNT_W'(MAX_ROWS);
    end
  end

  assign seen_plus1   = CNT_W'(rows_seen) + 1'b1;
  assign first_row    = (rows_seen == '0);
  assign last_row     = (seen_plus1 >= rows_eff);
  assign idx_prev_ext = CNT_W'(rows_seen - 1'b1);
  assign idx_cur_ext  = CNT_W'(rows_seen);

  assign row_stall  = q_low_space;
  assign row_accept = row_valid && !row_stall;

  // Lane group X: the row above the new one (or the lone first row)
  assign x_above = first_row ? '0 : upper_row;
  assign x_here  = first_row ? cur : middle_row;
  assign x_below = first_row ? '0 : cur;

  lgre_row #(.WIDTH(ROW_WIDTH)) u_row_x (
    .above    (x_above),
    .here     (x_here),
    .below    (x_below),
    .mask     (mask),
    .next_row (x_next)
  );

  // Lane group Y: the new row as the frame's last row
  lgre_row #(.WIDTH(ROW_WIDTH)) u_row_y (
    .above    (middle_row),
    .here     (cur),
    .below    ('0),
    .mask     (mask),
    .next_row (y_next)
  );

  // Merge into queue entries
  always_comb begin
    push.first    = row_accept && (!first_row || last_row);
    push.second   = row_accept && !first_row && last_row;
    entry0.bits   = DATA_W'(x_next);
    entry0.idx    = first_row ? '0 : idx_prev_ext[IDX_W-1:0];
    entry0.done   = first_row && last_row;
    entry1.bits   = DATA_W'(y_next);
    entry1.idx    = idx_cur_ext[IDX_W-1:0];
    entry1.done   = 1'b1;
  end

  // Row history and frame counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_row  <= '0;
      middle_row <= '0;
      rows_seen  <= '0;
    end else if (row_accept) begin
      if (last_row) begin
        upper_row  <= '0;
        middle_row <= '0;
        rows_seen  <= '0;
      end else begin
        upper_row  <= first_row ? '0 : (middle_row & mask);
        middle_row <= cur;
        rows_seen  <= seen_plus1[RW-1:0];
      end
    end
  end

  // Result queue
  assign pop = result_valid && !result_stall;

  lgre_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .entry0     (entry0),
    .entry1     (entry1),
    .pop        (pop),
    .valid      (result_valid),
    .low_space  (q_low_space),
    .head_entry (head_entry)
  );

  assign next_row_bits = head_entry.bits;
  assign row_index     = head_entry.idx;
  assign frame_done    = head_entry.done;

  a_second_with_first: assert property (@(posedge clk) disable iff (rst)
    push.second |-> push.first)
    else $error("second result pushed alone");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (row_accept && last_row) |=> (rows_seen == '0 && middle_row == '0))
    else $error("frame state not cleared at frame end");

  a_first_row_silent: assert property (@(posedge clk) disable iff (rst)
    (row_accept && first_row && !last_row) |-> !push.first)
    else $error("result pushed for a frame's first row");

  a_stored_masked: assert property (@(posedge clk) disable iff (rst)
    (row_accept && !last_row) |=> ((middle_row & ~$past(mask)) == '0))
    else $error("stored row holds bits outside the column mask");

endmodule
